// File: rtl/core/qda_pkg.sv
// Shared widths, register indexes and sideband types for the quadratic drag accelerator.
`default_nettype none
package qda_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int VEC_W         = 32;
    localparam int SUM_W         = 66;
    localparam int ROOT_W        = 33;
    localparam int DENS_W        = 23;
    localparam int COEF_W        = 21;
    localparam int MASS_W        = 32;
    localparam int IDX_W         = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_AIR_DENSITY  = 3'd0,
        REG_DRAG_COEF    = 3'd1,
        REG_CROSS_AREA   = 3'd2,
        REG_BODY_MASS    = 3'd3,
        REG_WIND_X       = 3'd4,
        REG_WIND_Y       = 3'd5,
        REG_WIND_Z       = 3'd6,
        REG_ENV_PRESENT  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [2:0][VEC_W-1:0] mag;
        logic [2:0]            neg;
    } t_side;
endpackage
`default_nettype wire

// File: rtl/core/quadratic_drag_accel_unit.sv
// Top level of the quadratic air drag acceleration unit: config registers and pipeline.
`default_nettype none
// Gives a = -0.5*rho*|r|*r*Cd*A/m for each velocity beat, r being velocity less wind
// (wind and the programmed density only while env_present is set; else no wind and
// density 1.225). Fixed point with FRAC_BITS fraction bits; each component saturates
// and raises o_clipped; zero speed or zero mass gives zeros. One beat is accepted
// every cycle while no finished result waits. The pipeline has 3 front stages, 33
// square-root stages, 35 + FRAC_BITS stages for the gain multiply and the
// one-bit-per-stage divide by mass, and 3 output scaling stages.
// The whole pipeline holds while a finished result waits. Write configuration only
// when no beat is in flight.
module quadratic_drag_accel_unit #(
    parameter int FRAC_BITS = qda_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic signed [31:0]            i_vel_x,
    input  wire logic signed [31:0]            i_vel_y,
    input  wire logic signed [31:0]            i_vel_z,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [31:0]                 o_acc_x,
    output logic signed [31:0]                 o_acc_y,
    output logic signed [31:0]                 o_acc_z,
    output logic                               o_clipped,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [qda_pkg::IDX_W-1:0]     i_cfg_index,
    input  wire logic [31:0]                   i_cfg_wdata
);
    import qda_pkg::*;

    localparam longint unsigned DefRho = ((64'd1225 << FRAC_BITS) + 64'd500) / 64'd1000;
    localparam int DefRhoW = $clog2(DefRho + 1);
    localparam int RHO_W   = (DefRhoW > DENS_W) ? DefRhoW : DENS_W;
    localparam int CDA_W   = 2*COEF_W - FRAC_BITS;
    localparam int K_W     = RHO_W + CDA_W - FRAC_BITS - 1;
    localparam int G_W     = FRAC_BITS + 33;

    logic [DENS_W-1:0]     r_air;
    logic [COEF_W-1:0]     r_cd;
    logic [COEF_W-1:0]     r_area;
    logic [MASS_W-1:0]     r_mass;
    logic [2:0][VEC_W-1:0] r_wind;
    logic                  r_env;

    logic [2*COEF_W-1:0]   cd_prod;
    logic [RHO_W+CDA_W-1:0] rk_prod;
    logic [CDA_W-1:0]      r_cda;
    logic [RHO_W-1:0]      r_rho;
    logic [K_W-1:0]        r_k;

    logic                  en;
    logic                  f_valid;
    logic [SUM_W-1:0]      f_sum;
    t_side                 f_side;
    logic                  q_valid;
    logic [ROOT_W-1:0]     q_root;
    t_side                 q_side;
    logic                  d_valid;
    logic [G_W-1:0]        d_g;
    logic                  d_zero;
    t_side                 d_side;
    logic [2:0][VEC_W-1:0] acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_air  <= DENS_W'(DefRho);
            r_cd   <= '0;
            r_area <= '0;
            r_mass <= MASS_W'(1) << FRAC_BITS;
            r_wind <= '0;
            r_env  <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_AIR_DENSITY: r_air     <= i_cfg_wdata[DENS_W-1:0];
                REG_DRAG_COEF:   r_cd      <= i_cfg_wdata[COEF_W-1:0];
                REG_CROSS_AREA:  r_area    <= i_cfg_wdata[COEF_W-1:0];
                REG_BODY_MASS:   r_mass    <= i_cfg_wdata[MASS_W-1:0];
                REG_WIND_X:      r_wind[0] <= i_cfg_wdata;
                REG_WIND_Y:      r_wind[1] <= i_cfg_wdata;
                REG_WIND_Z:      r_wind[2] <= i_cfg_wdata;
                REG_ENV_PRESENT: r_env     <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign cd_prod = r_cd * r_area;
    assign rk_prod = r_rho * r_cda;

    always_ff @(posedge i_clk) begin
        r_cda <= CDA_W'(cd_prod >> FRAC_BITS);
        r_rho <= r_env ? RHO_W'(r_air) : RHO_W'(DefRho);
        r_k   <= K_W'(rk_prod >> (FRAC_BITS + 1));
    end

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    qda_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_vel   ({i_vel_z, i_vel_y, i_vel_x}),
        .i_wind  (r_wind),
        .i_env   (r_env),
        .o_valid (f_valid),
        .o_sum   (f_sum),
        .o_side  (f_side)
    );

    qda_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_sum   (f_sum),
        .i_side  (f_side),
        .o_valid (q_valid),
        .o_root  (q_root),
        .o_side  (q_side)
    );

    qda_div #(
        .FRAC_BITS (FRAC_BITS),
        .K_W       (K_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q_valid),
        .i_root  (q_root),
        .i_k     (r_k),
        .i_mass  (r_mass),
        .i_side  (q_side),
        .o_valid (d_valid),
        .o_g     (d_g),
        .o_zero  (d_zero),
        .o_side  (d_side)
    );

    qda_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (d_valid),
        .i_g       (d_g),
        .i_zero    (d_zero),
        .i_side    (d_side),
        .o_valid   (o_valid),
        .o_acc     (acc),
        .o_clipped (o_clipped)
    );

    assign o_acc_x = acc[0];
    assign o_acc_y = acc[1];
    assign o_acc_z = acc[2];

`ifndef SYNTH
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("input taken while result stalled");

    a_zero_not_clipped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_acc_x == 32'sd0 && o_acc_y == 32'sd0 && o_acc_z == 32'sd0)
        |-> !o_clipped)
        else $error("clip flagged on zero result");

    a_clip_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clipped) |->
        (o_acc_x == 32'h7FFFFFFF || o_acc_x == 32'h80000000 ||
         o_acc_y == 32'h7FFFFFFF || o_acc_y == 32'h80000000 ||
         o_acc_z == 32'h7FFFFFFF || o_acc_z == 32'h80000000))
        else $error("clip flagged without a saturated component");
`endif
endmodule
`default_nettype wire

// File: rtl/core/qda_front.sv
// Front stages: subtract wind, take magnitudes, square and sum the components.
`default_nettype none
module qda_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_valid,
    input  wire logic [2:0][qda_pkg::VEC_W-1:0]      i_vel,
    input  wire logic [2:0][qda_pkg::VEC_W-1:0]      i_wind,
    input  wire logic                                i_env,
    output logic                                     o_valid,
    output logic [qda_pkg::SUM_W-1:0]                o_sum,
    output qda_pkg::t_side                           o_side
);
    import qda_pkg::*;

    logic [2:0][VEC_W:0]   diff;
    logic [2:0][VEC_W:0]   absd;
    t_side                 n_side;
    t_side                 r_side1, r_side2, r_side3;
    logic [2:0][2*VEC_W-1:0] r_sq;
    logic [SUM_W-1:0]      r_sum;
    logic [2:0]            r_vld;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            diff[l] = (VEC_W+1)'(signed'(i_vel[l]))
                    - (i_env ? (VEC_W+1)'(signed'(i_wind[l])) : '0);
            absd[l] = diff[l][VEC_W] ? ((VEC_W+1)'(0) - diff[l]) : diff[l];
            n_side.mag[l] = absd[l][VEC_W-1:0];
            n_side.neg[l] = !diff[l][VEC_W] && (diff[l] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side1 <= n_side;
            r_side2 <= r_side1;
            r_side3 <= r_side2;
            for (int l = 0; l < 3; l++) begin
                r_sq[l] <= r_side1.mag[l] * r_side1.mag[l];
            end
            r_sum <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    assign o_valid = r_vld[2];
    assign o_sum   = r_sum;
    assign o_side  = r_side3;
endmodule
`default_nettype wire

// File: rtl/core/qda_sqrt.sv
// Pipelined floor square root, one root bit per stage.
`default_nettype none
module qda_sqrt (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic                         i_valid,
    input  wire logic [qda_pkg::SUM_W-1:0]    i_sum,
    input  wire qda_pkg::t_side               i_side,
    output logic                              o_valid,
    output logic [qda_pkg::ROOT_W-1:0]        o_root,
    output qda_pkg::t_side                    o_side
);
    import qda_pkg::*;

    localparam int STAGES = ROOT_W;
    localparam int REM_W  = 2*ROOT_W - 30;

    logic [SUM_W-1:0]  st_sum  [0:STAGES];
    logic [REM_W-1:0]  st_rem  [0:STAGES];
    logic [ROOT_W-1:0] st_root [0:STAGES];
    t_side             st_side [0:STAGES];
    logic [STAGES:0]   st_vld;

    logic [SUM_W-1:0]  r_sum   [0:STAGES-1];
    logic [REM_W-1:0]  r_rem   [0:STAGES-1];
    logic [ROOT_W-1:0] r_root  [0:STAGES-1];
    t_side             r_side  [0:STAGES-1];
    logic [STAGES-1:0] r_vld;

    assign st_sum[0]  = i_sum;
    assign st_rem[0]  = '0;
    assign st_root[0] = '0;
    assign st_side[0] = i_side;
    assign st_vld[0]  = i_valid;

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        localparam int Pos = 2*(STAGES-1-s);
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;

        assign rem_sh = {st_rem[s][REM_W-3:0], st_sum[s][Pos+1:Pos]};
        assign trial  = REM_W'({st_root[s], 2'b01});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (rem_sh >= trial) begin
                    r_rem[s]  <= rem_sh - trial;
                    r_root[s] <= {st_root[s][ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[s]  <= rem_sh;
                    r_root[s] <= {st_root[s][ROOT_W-2:0], 1'b0};
                end
                r_sum[s]  <= st_sum[s];
                r_side[s] <= st_side[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= st_vld[s];
            end
        end

        assign st_sum[s+1]  = r_sum[s];
        assign st_rem[s+1]  = r_rem[s];
        assign st_root[s+1] = r_root[s];
        assign st_side[s+1] = r_side[s];
        assign st_vld[s+1]  = r_vld[s];
    end

    assign o_valid = st_vld[STAGES];
    assign o_root  = st_root[STAGES];
    assign o_side  = st_side[STAGES];
endmodule
`default_nettype wire

// File: rtl/core/qda_div.sv
// Gain stages: multiply drag constant by speed, then pipelined divide by mass with cap.
`default_nettype none
module qda_div #(
    parameter int FRAC_BITS = qda_pkg::FRAC_BITS_DEF,
    parameter int K_W       = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [qda_pkg::ROOT_W-1:0]    i_root,
    input  wire logic [K_W-1:0]                i_k,
    input  wire logic [qda_pkg::MASS_W-1:0]    i_mass,
    input  wire qda_pkg::t_side                i_side,
    output logic                               o_valid,
    output logic [FRAC_BITS+32:0]              o_g,
    output logic                               o_zero,
    output qda_pkg::t_side                     o_side
);
    import qda_pkg::*;

    localparam int SH  = 32 + FRAC_BITS;
    localparam int G_W = SH + 1;
    localparam int N_W = K_W + ROOT_W;
    localparam int ML  = 16;

    logic [K_W+ML-1:0]        r_pl;
    logic [K_W+ROOT_W-ML-1:0] r_ph;
    logic [N_W-1:0]           r_n;
    logic [N_W-1:0]           n_top;
    logic                     r_z0, r_z1;
    t_side                    r_s0, r_s1;
    logic [1:0]               r_v01;

    logic [MASS_W-1:0] st_rem  [0:SH];
    logic [SH-1:0]     st_low  [0:SH];
    logic [SH-1:0]     st_q    [0:SH];
    logic              st_ovf  [0:SH];
    logic              st_zero [0:SH];
    t_side             st_side [0:SH];
    logic [SH:0]       st_vld;

    logic [MASS_W-1:0] r_rem  [0:SH];
    logic [SH-1:0]     r_low  [0:SH];
    logic [SH-1:0]     r_q    [0:SH];
    logic              r_ovf  [0:SH];
    logic              r_zero [0:SH];
    t_side             r_side [0:SH];
    logic [SH:0]       r_vld;

    assign n_top = r_n >> SH;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pl <= i_k * i_root[ML-1:0];
            r_ph <= i_k * i_root[ROOT_W-1:ML];
            r_z0 <= (i_root == '0) || (i_mass == '0);
            r_s0 <= i_side;
            r_n  <= (N_W'(r_ph) << ML) + N_W'(r_pl);
            r_z1 <= r_z0;
            r_s1 <= r_s0;
            r_rem[0]  <= MASS_W'(n_top);
            r_low[0]  <= SH'(r_n);
            r_q[0]    <= '0;
            r_ovf[0]  <= n_top >= N_W'(i_mass);
            r_zero[0] <= r_z1;
            r_side[0] <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v01    <= '0;
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_v01    <= {r_v01[0], i_valid};
            r_vld[0] <= r_v01[1];
        end
    end

    for (genvar j = 0; j <= SH; j++) begin : g_tap
        assign st_rem[j]  = r_rem[j];
        assign st_low[j]  = r_low[j];
        assign st_q[j]    = r_q[j];
        assign st_ovf[j]  = r_ovf[j];
        assign st_zero[j] = r_zero[j];
        assign st_side[j] = r_side[j];
        assign st_vld[j]  = r_vld[j];
    end

    for (genvar j = 0; j < SH; j++) begin : g_stage
        logic [MASS_W:0] cur;
        logic [MASS_W:0] dif;
        logic            ge;

        assign cur = {st_rem[j], st_low[j][SH-1-j]};
        assign dif = cur - {1'b0, i_mass};
        assign ge  = cur >= {1'b0, i_mass};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1]  <= ge ? dif[MASS_W-1:0] : cur[MASS_W-1:0];
                r_q[j+1]    <= {st_q[j][SH-2:0], ge};
                r_low[j+1]  <= st_low[j];
                r_ovf[j+1]  <= st_ovf[j];
                r_zero[j+1] <= st_zero[j];
                r_side[j+1] <= st_side[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[j+1] <= st_vld[j];
            end
        end
    end

    assign o_valid = st_vld[SH];
    assign o_g     = st_ovf[SH] ? (G_W'(1) << SH) : {1'b0, st_q[SH]};
    assign o_zero  = st_zero[SH];
    assign o_side  = st_side[SH];
endmodule
`default_nettype wire

// File: rtl/core/qda_scale.sv
// Output stages: scale each magnitude by the gain, saturate, apply sign, hold the beat.
`default_nettype none
module qda_scale #(
    parameter int FRAC_BITS = qda_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire logic [FRAC_BITS+32:0]             i_g,
    input  wire logic                              i_zero,
    input  wire qda_pkg::t_side                    i_side,
    output logic                                   o_valid,
    output logic [2:0][qda_pkg::VEC_W-1:0]         o_acc,
    output logic                                   o_clipped
);
    import qda_pkg::*;

    localparam int G_W = FRAC_BITS + 33;
    localparam int GL  = G_W / 2;
    localparam int GH  = G_W - GL;
    localparam int P_W = G_W + VEC_W;
    localparam int V_W = P_W - FRAC_BITS;

    logic [2:0][VEC_W+GL-1:0] r_pl;
    logic [2:0][VEC_W+GH-1:0] r_ph;
    logic [2:0][P_W-1:0]      r_p;
    logic [2:0]               r_neg0, r_neg1;
    logic                     r_z0, r_z1;
    logic [1:0]               r_v;

    logic [2:0][V_W-1:0]      val;
    logic [2:0][V_W-1:0]      limit;
    logic [2:0]               sat;
    logic [2:0][VEC_W-1:0]    mag_o;
    logic [2:0][VEC_W-1:0]    n_acc;
    logic                     n_clip;
    logic [2:0][VEC_W-1:0]    r_acc;
    logic                     r_clip;
    logic                     r_ovld;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_pl[l] <= i_side.mag[l] * i_g[GL-1:0];
                r_ph[l] <= i_side.mag[l] * i_g[G_W-1:GL];
                r_p[l]  <= (P_W'(r_ph[l]) << GL) + P_W'(r_pl[l]);
            end
            r_neg0 <= i_side.neg;
            r_neg1 <= r_neg0;
            r_z0   <= i_zero;
            r_z1   <= r_z0;
            r_acc  <= n_acc;
            r_clip <= n_clip;
        end
    end

    always_comb begin
        n_clip = 1'b0;
        for (int l = 0; l < 3; l++) begin
            val[l]   = V_W'(r_p[l] >> FRAC_BITS);
            limit[l] = r_neg1[l] ? (V_W'(1) << (VEC_W-1)) : ((V_W'(1) << (VEC_W-1)) - V_W'(1));
            sat[l]   = val[l] > limit[l];
            mag_o[l] = sat[l] ? limit[l][VEC_W-1:0] : val[l][VEC_W-1:0];
            n_acc[l] = r_z1 ? '0 : (r_neg1[l] ? (VEC_W'(0) - mag_o[l]) : mag_o[l]);
            n_clip   = n_clip | (sat[l] & !r_z1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r_ovld <= 1'b0;
        end else if (i_en) begin
            r_v    <= {r_v[0], i_valid};
            r_ovld <= r_v[1];
        end
    end

    assign o_valid   = r_ovld;
    assign o_acc     = r_acc;
    assign o_clipped = r_clip;
endmodule
`default_nettype wire
